[sv/assert_macros.svh]
// Assertion macros used by the RTL of the centered-to-double converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define MLCD_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define MLCD_ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define MLCD_ASSERT(label, clk, rstn, prop, msg)
`define MLCD_ASSERT_NEVER(label, clk, rstn, expr, msg)
`endif
`endif

[sv/mlcd_pkg.sv]
// Shared types, constants and helpers of the centered-to-double converter.
`default_nettype none
package mlcd_pkg;

    localparam int MAX_LIMBS_DEF = 3;

    localparam logic [63:0] INV_SCALE_RESET = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] LIMB_WEIGHT     = 64'h43F0_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN     = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT       = 64'h0008_0000_0000_0000;

    // configuration register indexes
    localparam logic [2:0] REG_LIMB_COUNT = 3'd0;
    localparam logic [2:0] REG_INV_SCALE  = 3'd1;
    localparam logic [2:0] REG_THR_0      = 3'd2;
    localparam logic [2:0] REG_THR_1      = 3'd3;
    localparam logic [2:0] REG_THR_2      = 3'd4;
    localparam logic [2:0] REG_MOD_0      = 3'd5;
    localparam logic [2:0] REG_MOD_1      = 3'd6;
    localparam logic [2:0] REG_MOD_2      = 3'd7;

    typedef enum logic [1:0] {
        FOP_CVT = 2'd0,
        FOP_MUL = 2'd1,
        FOP_ADD = 2'd2,
        FOP_SUB = 2'd3
    } fop_t;

    typedef struct packed {
        logic start;
        fop_t op;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fpu_rsp_t;

    typedef struct packed {
        logic               sign;
        logic signed [13:0] expo;   // value = mant * 2^expo
        logic [52:0]        mant;
        logic               zero;
        logic               inf;
        logic               nan;
    } fp_unpk_t;

    function automatic fp_unpk_t fp_unpack(input logic [63:0] x);
        fp_unpk_t u;
        u.sign = x[63];
        u.zero = (x[62:52] == 11'h000) && (x[51:0] == 52'd0);
        u.inf  = (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
        u.nan  = (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
        u.mant = {x[62:52] != 11'h000, x[51:0]};
        u.expo = (x[62:52] == 11'h000) ? (14'sd1 - 14'sd1075)
                                       : ($signed({3'b000, x[62:52]}) - 14'sd1075);
        return u;
    endfunction

endpackage
`default_nettype wire

[sv/mlcd_fpu.sv]
// Multi-cycle IEEE double unit: uint64 convert, multiply, add, subtract (RNE).
`default_nettype none
module mlcd_fpu (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  mlcd_pkg::fpu_req_t  req,
    input  wire [63:0]          op_a,
    input  wire [63:0]          op_b,
    output mlcd_pkg::fpu_rsp_t  rsp
);
    import mlcd_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_MUL   = 5'b00010,
        F_ALIGN = 5'b00100,
        F_NORM  = 5'b01000,
        F_ROUND = 5'b10000
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic               s_reg, s_next;
    logic signed [13:0] e_reg, e_next;
    logic [127:0]       m_reg, m_next;
    logic [2:0]         step_reg, step_next;
    logic [52:0]        am_reg, am_next;
    logic [55:0]        bm_reg, bm_next;
    logic [7:0]         d_reg, d_next;
    logic               sub_reg, sub_next;
    logic               done_reg, done_next;
    logic [63:0]        res_reg, res_next;

    always_comb begin
        fp_unpk_t           ua, ub, ubig, usml;
        logic               sb_eff, a_big;
        logic signed [13:0] dexp, ebias, sh;
        logic [66:0]        pp;
        logic [127:0]       big_w, sml_w, sm, sum, mr;
        logic [6:0]         amt;
        logic [7:0]         shr;
        logic [10:0]        expf;
        logic               inc;
        logic [62:0]        mag;

        state_next = state_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        m_next     = m_reg;
        step_next  = step_reg;
        am_next    = am_reg;
        bm_next    = bm_reg;
        d_next     = d_reg;
        sub_next   = sub_reg;
        done_next  = 1'b0;
        res_next   = res_reg;

        ua     = fp_unpack(op_a);
        ub     = fp_unpack(op_b);
        sb_eff = (req.op == FOP_SUB) ? ~ub.sign : ub.sign;
        a_big  = op_a[62:0] >= op_b[62:0];
        ubig   = a_big ? ua : ub;
        usml   = a_big ? ub : ua;
        dexp   = ubig.expo - usml.expo;

        pp    = am_reg * bm_reg[55:42];
        big_w = {11'd0, am_reg, 64'd0};
        sml_w = {11'd0, bm_reg[52:0], 64'd0};
        if (d_reg[7]) begin
            sm = {127'd0, |sml_w};
        end else begin
            sm = (sml_w >> d_reg[6:0])
               | {127'd0, |(sml_w & ~({128{1'b1}} << d_reg[6:0]))};
        end
        sum = sub_reg ? (big_w - sm) : (big_w + sm);

        amt = 7'd64 >> step_reg;
        shr = 8'd128 - {1'b0, amt};

        ebias = e_reg + 14'sd1150;
        sh    = 14'sd1 - ebias;
        if (ebias >= 14'sd1) begin
            mr   = m_reg;
            expf = ebias[10:0];
        end else if (sh >= 14'sd128) begin
            mr   = 128'd1;
            expf = 11'd0;
        end else begin
            mr   = (m_reg >> sh[6:0])
                 | {127'd0, |(m_reg & ~({128{1'b1}} << sh[6:0]))};
            expf = 11'd0;
        end
        inc = mr[74] & ((|mr[73:0]) | mr[75]);
        mag = {expf, mr[126:75]} + {62'd0, inc};

        unique case (state_reg)
            F_IDLE: begin
                if (req.start) begin
                    unique case (req.op)
                        FOP_CVT: begin
                            if (op_a == 64'd0) begin
                                res_next  = 64'd0;
                                done_next = 1'b1;
                            end else begin
                                s_next     = 1'b0;
                                e_next     = 14'sd0;
                                m_next     = {64'd0, op_a};
                                step_next  = 3'd0;
                                state_next = F_NORM;
                            end
                        end
                        FOP_MUL: begin
                            if (ua.nan || ub.nan || ua.inf || ub.inf || ua.zero || ub.zero)
                            begin
                                done_next = 1'b1;
                                if (ua.nan) res_next = op_a | QUIET_BIT;
                                else if (ub.nan) res_next = op_b | QUIET_BIT;
                                else if ((ua.inf && ub.zero) || (ua.zero && ub.inf))
                                    res_next = DEFAULT_NAN;
                                else if (ua.inf || ub.inf)
                                    res_next = {ua.sign ^ ub.sign, 11'h7FF, 52'd0};
                                else
                                    res_next = {ua.sign ^ ub.sign, 63'd0};
                            end else begin
                                s_next     = ua.sign ^ ub.sign;
                                e_next     = ua.expo + ub.expo;
                                m_next     = 128'd0;
                                am_next    = ua.mant;
                                bm_next    = {3'd0, ub.mant};
                                step_next  = 3'd3;
                                state_next = F_MUL;
                            end
                        end
                        FOP_ADD, FOP_SUB: begin
                            if (ua.nan || ub.nan || ua.inf || ub.inf || ua.zero || ub.zero)
                            begin
                                done_next = 1'b1;
                                if (ua.nan) res_next = op_a | QUIET_BIT;
                                else if (ub.nan) res_next = op_b | QUIET_BIT;
                                else if (ua.inf && ub.inf && (ua.sign != sb_eff))
                                    res_next = DEFAULT_NAN;
                                else if (ua.inf) res_next = op_a;
                                else if (ub.inf) res_next = {sb_eff, op_b[62:0]};
                                else if (ua.zero && ub.zero)
                                    res_next = {ua.sign & sb_eff, 63'd0};
                                else if (ua.zero) res_next = {sb_eff, op_b[62:0]};
                                else res_next = op_a;
                            end else begin
                                s_next     = a_big ? ua.sign : sb_eff;
                                sub_next   = ua.sign ^ sb_eff;
                                e_next     = ubig.expo - 14'sd64;
                                d_next     = (dexp > 14'sd127) ? 8'd128 : {1'b0, dexp[6:0]};
                                am_next    = ubig.mant;
                                bm_next    = {3'd0, usml.mant};
                                state_next = F_ALIGN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            F_MUL: begin
                // one 53x14 partial product per cycle, top chunk first
                m_next  = (m_reg << 14) + {61'd0, pp};
                bm_next = bm_reg << 14;
                if (step_reg == 3'd0) begin
                    state_next = F_NORM;
                end else begin
                    step_next = step_reg - 3'd1;
                end
            end
            F_ALIGN: begin
                if (sum == 128'd0) begin
                    res_next   = 64'd0;
                    done_next  = 1'b1;
                    state_next = F_IDLE;
                end else begin
                    m_next     = sum;
                    step_next  = 3'd0;
                    state_next = F_NORM;
                end
            end
            F_NORM: begin
                // shift by 64, 32, ... 1 when the top bits are clear
                if ((m_reg >> shr) == 128'd0) begin
                    m_next = m_reg << amt;
                    e_next = e_reg - $signed({7'd0, amt});
                end
                if (step_reg == 3'd6) begin
                    state_next = F_ROUND;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            F_ROUND: begin
                if (ebias >= 14'sd2047) res_next = {s_reg, 11'h7FF, 52'd0};
                else res_next = {s_reg, mag};
                done_next  = 1'b1;
                state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        s_reg    <= s_next;
        e_reg    <= e_next;
        m_reg    <= m_next;
        step_reg <= step_next;
        am_reg   <= am_next;
        bm_reg   <= bm_next;
        d_reg    <= d_next;
        sub_reg  <= sub_next;
        res_reg  <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule
`default_nettype wire

[sv/multi_limb_centered_to_double_core.sv]
// Multi-limb centered coefficient to IEEE double converter. Limbs arrive one per item,
// lowest first, and are taken while s_tready is high; an item that is not the last limb of
// a coefficient gives no result. On the last limb the block drops s_tready and a sequencer
// compares the coefficient with the threshold from the top limb (one limb a cycle), then
// for each limb forms the term, converts it, scales it and accumulates it, all through one
// shared multi-cycle double unit. Special operands (zero, inf, NaN) finish early in that
// unit, and an add that cancels to zero skips normalising. A zero term skips convert
// and multiply. Each limb but the last also steps the scale by 2^64 in the unit, and the
// sum is then loaded into the output register, where the result sits; the input reopens
// as soon as it is loaded, so the next coefficient's limbs are taken while the result
// waits, and only a finished coefficient whose result register is still full holds the
// sequencer (and the input) back.
`default_nettype none
`include "assert_macros.svh"
module multi_limb_centered_to_double_core #(
    parameter int MAX_LIMBS = mlcd_pkg::MAX_LIMBS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,       // [63:0] limb_value
    input  wire         s_tlast,       // end_of_block
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,       // [63:0] real_bits
    output logic        m_tlast,       // end_of_block_res
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_wr_index,
    input  wire  [63:0] cfg_wr_data
);
    import mlcd_pkg::*;

    localparam int IDX_W = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CMP  = 8'b0000_0010,
        S_DIFF = 8'b0000_0100,
        S_CVT  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_ACC  = 8'b0010_0000,
        S_SCL  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    // configuration
    logic [1:0]  limb_count_reg;
    logic [63:0] inv_scale_reg;
    logic [63:0] thr_reg [3];
    logic [63:0] mod_reg [3];

    // limb store, no reset: every entry read was written since the limb index last restarted at zero
    logic [63:0] limb_store [MAX_LIMBS];

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] limb_index_reg, limb_index_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             below_reg, below_next;
    logic             eob_reg, eob_next;
    logic [63:0]      diff_reg, diff_next;
    logic             add_reg, add_next;
    logic [63:0]      term_reg, term_next;
    logic [63:0]      acc_reg, acc_next;
    logic [63:0]      scale_reg, scale_next;
    logic             fpu_busy_reg, fpu_busy_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [63:0]      m_tdata_reg, m_tdata_next;
    logic             m_tlast_reg, m_tlast_next;

    logic             accept;
    logic [1:0]       eff_cnt;
    logic [IDX_W-1:0] idx;
    logic             last_limb;
    logic [63:0]      cur_limb;
    logic [63:0]      cur_thr;
    logic [63:0]      cur_mod;

    fpu_req_t    fpu_req;
    fpu_rsp_t    fpu_rsp;
    logic [63:0] fpu_a, fpu_b;

    mlcd_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .op_a    (fpu_a),
        .op_b    (fpu_b),
        .rsp     (fpu_rsp)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // count zero means one limb, and the count saturates at the store depth
    always_comb begin
        eff_cnt = (limb_count_reg == 2'd0) ? 2'd1 : limb_count_reg;
        if (eff_cnt > 2'(MAX_LIMBS)) eff_cnt = 2'(MAX_LIMBS);
        idx = limb_index_reg;
        if (32'(limb_index_reg) > MAX_LIMBS - 1) idx = IDX_W'(MAX_LIMBS - 1);
    end

    assign last_limb = (3'(idx) + 3'd1) >= {1'b0, eff_cnt};
    assign cur_limb  = limb_store[j_reg];
    assign cur_thr   = thr_reg[2'(j_reg)];
    assign cur_mod   = mod_reg[2'(j_reg)];

    always_comb begin
        state_next      = state_reg;
        limb_index_next = limb_index_reg;
        j_next          = j_reg;
        cnt_next        = cnt_reg;
        below_next      = below_reg;
        eob_next        = eob_reg;
        diff_next       = diff_reg;
        add_next        = add_reg;
        term_next       = term_reg;
        acc_next        = acc_reg;
        scale_next      = scale_reg;
        fpu_busy_next   = fpu_busy_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        fpu_req.start   = 1'b0;
        fpu_req.op      = FOP_CVT;
        fpu_a           = diff_reg;
        fpu_b           = scale_reg;

        if (m_tvalid_reg && m_tready) m_tvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (last_limb) begin
                        cnt_next        = eff_cnt;
                        eob_next        = s_tlast;
                        j_next          = IDX_W'(eff_cnt - 2'd1);
                        limb_index_next = '0;
                        state_next      = S_CMP;
                    end else begin
                        limb_index_next = idx + IDX_W'(1);
                    end
                end
            end
            S_CMP: begin
                // top limb down; the first unequal limb decides
                if (cur_limb < cur_thr) begin
                    below_next = 1'b1;
                    j_next     = '0;
                    state_next = S_DIFF;
                end else if ((cur_limb > cur_thr) || (j_reg == '0)) begin
                    below_next = 1'b0;
                    j_next     = '0;
                    state_next = S_DIFF;
                end else begin
                    j_next = j_reg - IDX_W'(1);
                end
                acc_next   = 64'd0;
                scale_next = inv_scale_reg;
            end
            S_DIFF: begin
                if (below_reg) begin
                    diff_next = cur_limb;
                    add_next  = 1'b1;
                end else if (cur_limb > cur_mod) begin
                    diff_next = cur_limb - cur_mod;
                    add_next  = 1'b1;
                end else begin
                    diff_next = cur_mod - cur_limb;
                    add_next  = 1'b0;
                end
                // a zero term is +0 and skips the convert and the scale multiply
                if (diff_next == 64'd0) begin
                    term_next  = 64'd0;
                    state_next = S_ACC;
                end else begin
                    state_next = S_CVT;
                end
            end
            S_CVT: begin
                fpu_req.op = FOP_CVT;
                fpu_a      = diff_reg;
                if (!fpu_busy_reg) begin
                    fpu_req.start = 1'b1;
                    fpu_busy_next = 1'b1;
                end else if (fpu_rsp.done) begin
                    fpu_busy_next = 1'b0;
                    term_next     = fpu_rsp.result;
                    state_next    = S_MUL;
                end
            end
            S_MUL: begin
                fpu_req.op = FOP_MUL;
                fpu_a      = term_reg;
                fpu_b      = scale_reg;
                if (!fpu_busy_reg) begin
                    fpu_req.start = 1'b1;
                    fpu_busy_next = 1'b1;
                end else if (fpu_rsp.done) begin
                    fpu_busy_next = 1'b0;
                    term_next     = fpu_rsp.result;
                    state_next    = S_ACC;
                end
            end
            S_ACC: begin
                fpu_req.op = add_reg ? FOP_ADD : FOP_SUB;
                fpu_a      = acc_reg;
                fpu_b      = term_reg;
                if (!fpu_busy_reg) begin
                    fpu_req.start = 1'b1;
                    fpu_busy_next = 1'b1;
                end else if (fpu_rsp.done) begin
                    fpu_busy_next = 1'b0;
                    acc_next      = fpu_rsp.result;
                    if ((3'(j_reg) + 3'd1) < 3'(cnt_reg)) state_next = S_SCL;
                    else state_next = S_OUT;
                end
            end
            S_SCL: begin
                // next limb weighs 2^64 more
                fpu_req.op = FOP_MUL;
                fpu_a      = scale_reg;
                fpu_b      = LIMB_WEIGHT;
                if (!fpu_busy_reg) begin
                    fpu_req.start = 1'b1;
                    fpu_busy_next = 1'b1;
                end else if (fpu_rsp.done) begin
                    fpu_busy_next = 1'b0;
                    scale_next    = fpu_rsp.result;
                    j_next        = j_reg + IDX_W'(1);
                    state_next    = S_DIFF;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg;
                    m_tlast_next  = eob_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limb_count_reg <= 2'd1;
            inv_scale_reg  <= INV_SCALE_RESET;
            thr_reg[0]     <= 64'd0;
            thr_reg[1]     <= 64'd0;
            thr_reg[2]     <= 64'd0;
            mod_reg[0]     <= 64'd0;
            mod_reg[1]     <= 64'd0;
            mod_reg[2]     <= 64'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_LIMB_COUNT: limb_count_reg <= cfg_wr_data[1:0];
                REG_INV_SCALE:  inv_scale_reg  <= cfg_wr_data;
                REG_THR_0:      thr_reg[0]     <= cfg_wr_data;
                REG_THR_1:      thr_reg[1]     <= cfg_wr_data;
                REG_THR_2:      thr_reg[2]     <= cfg_wr_data;
                REG_MOD_0:      mod_reg[0]     <= cfg_wr_data;
                REG_MOD_1:      mod_reg[1]     <= cfg_wr_data;
                REG_MOD_2:      mod_reg[2]     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) limb_store[idx] <= s_tdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            limb_index_reg <= '0;
            fpu_busy_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            limb_index_reg <= limb_index_next;
            fpu_busy_reg   <= fpu_busy_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        j_reg       <= j_next;
        cnt_reg     <= cnt_next;
        below_reg   <= below_next;
        eob_reg     <= eob_next;
        diff_reg    <= diff_next;
        add_reg     <= add_next;
        term_reg    <= term_next;
        acc_reg     <= acc_next;
        scale_reg   <= scale_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    `MLCD_ASSERT_NEVER(a_idle_fpu_quiet, aclk, aresetn, (state_reg == S_IDLE) && fpu_busy_reg, "FPU busy while sequencer idle")
    `MLCD_ASSERT(a_done_when_busy, aclk, aresetn, fpu_rsp.done |-> fpu_busy_reg, "FPU result without a request")
    `MLCD_ASSERT(a_limb_in_range, aclk, aresetn, (state_reg == S_DIFF) |-> (3'(j_reg) < 3'(cnt_reg)), "limb position past count")

endmodule
`default_nettype wire

[test/multi_limb_centered_to_double_core_test.sv]
// Testbench for the multi-limb centered-to-double converter: directed table, then random phases.
`timescale 1ns / 1ps
`default_nettype none
module multi_limb_centered_to_double_core_test;
    import mlcd_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE = 100;   // cycles of block latency allowed after the last result
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;   // [63:0] limb_value
    logic s_tlast;          // end_of_block
    logic m_tvalid;
    logic m_tready;
    logic [63:0] m_tdata;   // [63:0] real_bits
    logic m_tlast;          // end_of_block_res
    logic cfg_wr_en;
    logic [2:0] cfg_wr_index;
    logic [63:0] cfg_wr_data;

    multi_limb_centered_to_double_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    typedef struct {
        logic [63:0] real_bits;
        logic        eob;
    } coeff_result_t;

    // one directed item; want_bits is typed in only where want_typed is set,
    // new_setup switches to the second directed register set before the item
    typedef struct {
        logic        new_setup;
        logic [63:0] limb;
        logic        last;
        logic        want_typed;
        logic [63:0] want_bits;
    } limb_row_t;

    coeff_result_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    bit rx_hold_req = 0;

    // shadow copy of the block's registers and limb store
    logic [1:0]  sh_count;
    logic [63:0] sh_scale;
    logic [63:0] sh_thr [3];
    logic [63:0] sh_mod [3];
    logic [63:0] sh_store [3];
    logic [1:0]  sh_index;

    // ---------------- clock, reset, timeout ----------------
    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- prediction ----------------
    // unsigned 64-bit integer to double, round to nearest even
    function automatic logic [63:0] u64_to_double(input logic [63:0] x);
        int p;
        int sh;
        logic [63:0] m;
        logic [63:0] rem;
        logic [63:0] half;
        logic [10:0] ex;
        if (x == 0) return 64'd0;
        p = 63;
        while (!x[p]) p--;
        if (p <= 52) begin
            m = x << (52 - p);
        end else begin
            sh = p - 52;
            m = x >> sh;
            rem = x & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0])) m = m + 64'd1;
            if (m[53]) begin
                m = m >> 1;
                p++;
            end
        end
        ex = 11'(p + 1023);
        return {1'b0, ex, m[51:0]};
    endfunction

    function automatic logic [63:0] centered_value(input int cnt);
        bit below;
        bit equal;
        bit add;
        real scale;
        real acc;
        real term;
        logic [63:0] diff;
        below = 0;
        equal = 1;
        for (int j = cnt - 1; j >= 0 && equal; j--) begin
            if (sh_store[j] < sh_thr[j]) below = 1;
            equal = (sh_store[j] == sh_thr[j]);
        end
        scale = $bitstoreal(sh_scale);
        acc = 0.0;
        for (int j = 0; j < cnt; j++) begin
            if (below) begin
                diff = sh_store[j];
                add = 1;
            end else if (sh_store[j] > sh_mod[j]) begin
                diff = sh_store[j] - sh_mod[j];
                add = 1;
            end else begin
                diff = sh_mod[j] - sh_store[j];
                add = 0;
            end
            term = $bitstoreal(u64_to_double(diff));
            if (diff != 0) term = term * scale;   // zero term stays +0 even for inf scale
            acc = add ? acc + term : acc - term;
            scale = scale * 18446744073709551616.0;
        end
        return $realtobits(acc);
    endfunction

    // takes one accepted limb; returns 1 and the result when a coefficient completes
    function automatic bit predict_limb(input logic [63:0] limb, input logic eob,
                                        output coeff_result_t res);
        int cnt;
        int idx;
        cnt = (sh_count == 0) ? 1 : sh_count;
        idx = (sh_index > 2) ? 2 : sh_index;
        sh_store[idx] = limb;
        if (idx + 1 >= cnt) begin
            res.real_bits = centered_value(cnt);
            res.eob = eob;
            sh_index = 0;
            return 1;
        end
        sh_index = 2'(idx + 1);
        return 0;
    endfunction

    // ---------------- result check ----------------
    always @(posedge aclk) begin
        coeff_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: real_bits %h", m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.real_bits) begin
                    $error("real_bits expected %h actual %h", want.real_bits, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.eob) begin
                    $error("end_of_block_res expected %b actual %b", want.eob, m_tlast);
                    errors++;
                end
            end
        end
    end

    // ---------------- receiver ----------------
    initial begin
        int stall;
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            stall = $urandom_range(0, 3);
            if (rx_hold_req) begin
                rx_hold_req = 0;
                stall = 400;   // long hold-off: block fills and stalls its input
            end
            if (stall > 0) begin
                m_tready <= 0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
        case (idx)
            REG_LIMB_COUNT: sh_count = val[1:0];
            REG_INV_SCALE:  sh_scale = val;
            REG_THR_0:      sh_thr[0] = val;
            REG_THR_1:      sh_thr[1] = val;
            REG_THR_2:      sh_thr[2] = val;
            REG_MOD_0:      sh_mod[0] = val;
            REG_MOD_1:      sh_mod[1] = val;
            default:        sh_mod[2] = val;
        endcase
    endtask

    // offer one item after a random gap; valid stays high across back-to-back items
    task automatic send_limb(input logic [63:0] limb, input logic eob,
                             input bit typed, input logic [63:0] typed_bits);
        int gap;
        coeff_result_t res;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= limb;
        s_tlast <= eob;
        do @(posedge aclk); while (!s_tready);
        if (predict_limb(limb, eob, res)) begin
            if (typed) res.real_bits = typed_bits;
            pending_results.push_back(res);
        end
    endtask

    // stop offering, wait for every expected result, then let the block settle
    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [63:0] pick_scale;
        case ($urandom_range(0, 7))
            0: return 64'h3FF0_0000_0000_0000;   // 1.0
            1: return 64'h3BF0_0000_0000_0000;   // 2^-64
            2: return 64'h7FF0_0000_0000_0000;   // +inf
            3: return 64'h0000_0000_0000_0001;   // smallest subnormal
            4: return 64'h7FEF_FFFF_FFFF_FFFF;   // largest finite
            5: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'd1023 - 11'($urandom_range(0, 200)),
                       $urandom(), 20'($urandom())};
            6: return 64'd0;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [63:0] pick_limb(input int j);
        case ($urandom_range(0, 19))
            0, 1, 2:  return sh_thr[j] + 64'($signed($urandom_range(0, 2)) - 1);
            3, 4, 5:  return sh_mod[j] + 64'($signed($urandom_range(0, 2)) - 1);
            6:        return 64'd0;
            7:        return ALL_ONES;
            8:        return 64'h8000_0000_0000_0000;
            default:  return {$urandom(), $urandom()};
        endcase
    endfunction

    limb_row_t directed_rows [] = '{
        // reset setting: one limb, scale 1.0, threshold and modulus zero
        '{0, 64'd0,    0, 1, 64'h0000_0000_0000_0000},
        '{0, 64'd1,    1, 1, 64'h3FF0_0000_0000_0000},
        '{0, ALL_ONES, 0, 1, 64'h43F0_0000_0000_0000},
        '{0, 64'h8000_0000_0000_0000, 1, 1, 64'h43E0_0000_0000_0000},
        // three limbs: equal to threshold
        '{1, 64'd5,  0, 0, 0}, '{0, 64'd6,  0, 0, 0}, '{0, 64'd7,  1, 0, 0},
        // below threshold, decided at the lowest limb
        '{0, 64'd4,  0, 0, 0}, '{0, 64'd6,  0, 0, 0}, '{0, 64'd7,  0, 0, 0},
        // above threshold at the top limb
        '{0, 64'd0,  0, 0, 0}, '{0, 64'd0,  0, 0, 0}, '{0, 64'd8,  1, 0, 0},
        // every limb equal to the modulus: all terms zero
        '{0, 64'd10, 0, 0, 0}, '{0, 64'd20, 0, 0, 0}, '{0, 64'd30, 0, 0, 0},
        // all extremes
        '{0, ALL_ONES, 0, 0, 0}, '{0, ALL_ONES, 0, 0, 0}, '{0, ALL_ONES, 1, 0, 0},
        '{0, 64'd0,  0, 0, 0}, '{0, 64'd0,  0, 0, 0}, '{0, 64'd0,  0, 0, 0},
        // two limbs of a coefficient, then the count is lowered
        '{0, 64'd9,  0, 0, 0}, '{0, 64'd3,  0, 0, 0}
    };

    initial begin
        int sent;
        int n;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        cfg_wr_en = 0;
        cfg_wr_index = 0;
        cfg_wr_data = 0;
        aresetn = 0;
        sh_count = 1;
        sh_scale = INV_SCALE_RESET;
        for (int j = 0; j < 3; j++) begin
            sh_thr[j] = 0;
            sh_mod[j] = 0;
            sh_store[j] = 0;
        end
        sh_index = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // ---- directed part ----
        foreach (directed_rows[i]) begin
            if (directed_rows[i].new_setup) begin
                drain();
                write_reg(REG_LIMB_COUNT, 64'd3);
                write_reg(REG_INV_SCALE, 64'h3BF0_0000_0000_0000);
                write_reg(REG_THR_0, 64'd5);
                write_reg(REG_THR_1, 64'd6);
                write_reg(REG_THR_2, 64'd7);
                write_reg(REG_MOD_0, 64'd10);
                write_reg(REG_MOD_1, 64'd20);
                write_reg(REG_MOD_2, 64'd30);
            end
            send_limb(directed_rows[i].limb, directed_rows[i].last,
                      directed_rows[i].want_typed, directed_rows[i].want_bits);
        end
        // count lowered mid-coefficient, then count zero (treated as one)
        drain();
        write_reg(REG_LIMB_COUNT, 64'd1);
        send_limb(64'd2, 1, 0, 0);
        drain();
        write_reg(REG_LIMB_COUNT, 64'd0);
        send_limb(64'd12, 0, 0, 0);
        send_limb(ALL_ONES, 1, 0, 0);

        // ---- random phases ----
        sent = 0;
        for (int ph = 0; sent < 1000; ph++) begin
            drain();   // sender pauses until every result has come
            write_reg(REG_LIMB_COUNT, 64'($urandom_range(0, 3)));
            write_reg(REG_INV_SCALE, pick_scale());
            for (int j = 0; j < 3; j++) begin
                write_reg(REG_MOD_0 + 3'(j), $urandom_range(0, 5) == 0 ?
                          ($urandom_range(0, 1) ? ALL_ONES : 64'd0) : {$urandom(), $urandom()});
                write_reg(REG_THR_0 + 3'(j), $urandom_range(0, 2) == 0 ?
                          sh_mod[j] >> 1 : {$urandom(), $urandom()});
            end
            if (ph == 2) rx_hold_req = 1;
            n = $urandom_range(90, 140);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 15) == 0)
                    send_limb({$urandom(), $urandom()}, 1'($urandom()), 0, 0);   // noise
                else
                    send_limb(pick_limb(sh_index > 2 ? 2 : sh_index), 1'($urandom()), 0, 0);
            end
            sent += n;
        end

        drain();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
+incdir+sv
sv/mlcd_pkg.sv
sv/mlcd_fpu.sv
sv/multi_limb_centered_to_double_core.sv
test/multi_limb_centered_to_double_core_test.sv
